### rtl/core/mdss_pkg.sv
// Package: types, constants and helper functions for the seven-segment scan driver.
`default_nettype none
package mdss_pkg;

  localparam int unsigned NumDigits  = 5;
  localparam int unsigned DigitCount = 4;
  localparam int unsigned ColW       = 3;
  localparam int unsigned QueueDepth = 2;

  localparam logic [ColW-1:0] ColWrap = ColW'(DigitCount);

  localparam logic [16:0] Unit10000 = 17'd10000;
  localparam logic [16:0] Unit1000  = 17'd1000;
  localparam logic [16:0] Unit100   = 17'd100;
  localparam logic [16:0] Unit10    = 17'd10;

  // segment on-patterns, bit0 = a ... bit6 = g
  localparam logic [7:0] SegOn [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h67
  };

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_SCAN = 1'b1
  } op_e;

  typedef struct packed {
    logic        kind;
    logic [15:0] value;
  } in_t;

  typedef struct packed {
    logic [4:0] column_select;
    logic [7:0] segments;
  } out_t;

  typedef struct packed {
    op_e         op;
    logic [15:0] value;
  } fe_item_t;

  // item leaving the digit split pipeline
  typedef struct packed {
    op_e        op;
    logic [3:0] d4;
    logic [3:0] d3;
    logic [3:0] d2;
    logic [6:0] rem;
  } sp_item_t;

  typedef struct packed {
    logic [3:0]  q;
    logic [16:0] r;
  } dstep_t;

  // one decimal digit by parallel compares against the multiples of unit;
  // rem must be below ten times unit
  function automatic dstep_t digit_step(input logic [16:0] rem, input logic [16:0] unit);
    dstep_t res;
    res.q = 4'd0;
    res.r = rem;
    for (int unsigned k = 1; k < 10; k++) begin
      if (rem >= 17'(k) * unit) begin
        res.q = 4'(k);
        res.r = rem - 17'(k) * unit;
      end
    end
    return res;
  endfunction

  function automatic logic [7:0] seg_pattern(input logic [3:0] d);
    logic [7:0] pat;
    if (d > 4'd9) begin
      pat = 8'hFF;
    end else begin
      pat = ~SegOn[d];
    end
    return pat;
  endfunction

endpackage
`default_nettype wire

### rtl/core/mdss_front.sv
// Front end: input queue that takes beats and classifies them as load or scan.
`default_nettype none
module mdss_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire mdss_pkg::in_t     in_i,
  output logic                   fe_vld_o,
  input  wire logic              fe_rdy_i,
  output mdss_pkg::fe_item_t     fe_item_o
);
  import mdss_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  fe_item_t          mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;
  fe_item_t          item;

  assign full      = (cnt_q == CntW'(QueueDepth));
  assign fe_vld_o  = (cnt_q != '0);
  assign fe_item_o = mem_q[rd_ptr_q];

  assign do_push = push && !full;
  assign do_pop  = fe_vld_o && fe_rdy_i;

  always_comb begin
    item.op    = in_i.kind ? OP_SCAN : OP_LOAD;
    item.value = in_i.value;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

endmodule
`default_nettype wire

### rtl/core/mdss_split.sv
// Decimal split pipeline: ten-thousands, thousands and hundreds digits, one per stage.
`default_nettype none
module mdss_split (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 fe_vld_i,
  output logic                      fe_rdy_o,
  input  wire mdss_pkg::fe_item_t   fe_item_i,
  input  wire logic                 adv_i,
  output logic                      sp_vld_o,
  output mdss_pkg::sp_item_t        sp_item_o
);
  import mdss_pkg::*;

  logic        v1_q, v2_q, v3_q;
  op_e         op1_q, op2_q;
  logic [3:0]  d4_1_q, d4_2_q;
  logic [3:0]  d3_2_q;
  logic [13:0] rem1_q;
  logic [9:0]  rem2_q;
  sp_item_t    s3_q, s3_d;
  dstep_t      st1, st2, st3;

  assign fe_rdy_o  = adv_i;
  assign sp_vld_o  = v3_q;
  assign sp_item_o = s3_q;

  assign st1 = digit_step({1'b0, fe_item_i.value}, Unit10000);
  assign st2 = digit_step({3'b0, rem1_q}, Unit1000);
  assign st3 = digit_step({7'b0, rem2_q}, Unit100);

  always_comb begin
    s3_d.op  = op2_q;
    s3_d.d4  = d4_2_q;
    s3_d.d3  = d3_2_q;
    s3_d.d2  = st3.q;
    s3_d.rem = st3.r[6:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= fe_vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      op1_q  <= fe_item_i.op;
      d4_1_q <= st1.q;
      rem1_q <= st1.r[13:0];
      op2_q  <= op1_q;
      d4_2_q <= d4_1_q;
      d3_2_q <= st2.q;
      rem2_q <= st2.r[9:0];
      s3_q   <= s3_d;
    end
  end

endmodule
`default_nettype wire

### rtl/core/mdss_back.sv
// Back end: digit store, column scan and the result queue.
`default_nettype none
module mdss_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 sp_vld_i,
  input  wire mdss_pkg::sp_item_t   sp_item_i,
  output logic                      adv_o,
  output logic                      empty,
  input  wire logic                 pop,
  output mdss_pkg::out_t            out_o
);
  import mdss_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [3:0]      digits_q [NumDigits];
  logic [ColW-1:0] col_q, col_d, col_inc;
  dstep_t          st;
  logic            is_load, is_scan;
  out_t            res;

  out_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            q_full, do_push, do_pop;

  assign q_full  = (cnt_q == CntW'(QueueDepth));
  assign empty   = (cnt_q == '0);
  assign out_o   = mem_q[rd_ptr_q];

  assign is_scan = sp_vld_i && (sp_item_i.op == OP_SCAN);
  assign is_load = sp_vld_i && (sp_item_i.op == OP_LOAD) && adv_o;
  // only a scan needs a free slot in the result queue
  assign adv_o   = !(is_scan && q_full);
  assign do_push = is_scan && !q_full;
  assign do_pop  = pop && !empty;

  assign st = digit_step({10'b0, sp_item_i.rem}, Unit10);

  always_comb begin
    col_inc = col_q + 1'b1;
    col_d   = (col_inc >= ColWrap) ? '0 : col_inc;
    res.column_select = ~(5'(1) << col_d);
    res.segments      = seg_pattern(digits_q[col_d]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      for (int unsigned i = 0; i < NumDigits; i++) begin
        digits_q[i] <= 4'd0;
      end
    end else begin
      if (do_push) begin
        col_q <= col_d;
      end
      if (is_load) begin
        digits_q[4] <= sp_item_i.d4;
        digits_q[3] <= sp_item_i.d3;
        digits_q[2] <= sp_item_i.d2;
        digits_q[1] <= st.q;
        digits_q[0] <= st.r[3:0];
      end
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= res;
    end
  end

endmodule
`default_nettype wire

### rtl/core/multiplexed_decimal_seven_segment_scan.sv
// Top level: multiplexed decimal seven-segment scan driver.
// Input beats enter through push/full; a beat with kind 0 loads a 16-bit
// value that is split into five decimal digits (column 0 = ones), a beat
// with kind 1 is a scan tick. Each scan tick advances the column (wrapping
// at DigitCount) and yields one result beat: an active-low one-cold column
// mask and the active-low segments of that column's digit, decimal point
// off. Loads yield nothing. Results leave through empty/pop, oldest first.
// A scan's result reaches out_o through the input queue, the three split
// stages and the result queue, each of which holds it in registers.
// Throughput: one beat per cycle, loads and scans alike, unless a stall holds
// the pipeline; the digit split takes one decimal digit per pipeline stage.
// Reset: queues empty, all digits zero, column zero, so the first tick
// shows column 1.
// Stall: when the two-entry result queue is full, a scan at the end of the
// split pipeline waits and the pipeline holds; the two-entry input queue
// then fills and full rises. Nothing is dropped.
`default_nettype none
module multiplexed_decimal_seven_segment_scan (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push,
  output logic                 full,
  input  wire mdss_pkg::in_t   in_i,
  output logic                 empty,
  input  wire logic            pop,
  output mdss_pkg::out_t       out_o
);
  import mdss_pkg::*;

  logic      fe_vld, fe_rdy;
  fe_item_t  fe_item;
  logic      sp_vld, adv;
  sp_item_t  sp_item;

  mdss_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_i      (in_i),
    .fe_vld_o  (fe_vld),
    .fe_rdy_i  (fe_rdy),
    .fe_item_o (fe_item)
  );

  mdss_split u_split (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fe_vld_i  (fe_vld),
    .fe_rdy_o  (fe_rdy),
    .fe_item_i (fe_item),
    .adv_i     (adv),
    .sp_vld_o  (sp_vld),
    .sp_item_o (sp_item)
  );

  mdss_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sp_vld_i  (sp_vld),
    .sp_item_i (sp_item),
    .adv_o     (adv),
    .empty     (empty),
    .pop       (pop),
    .out_o     (out_o)
  );

  // a waiting result drives exactly one column
  a_one_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> $countones(~out_o.column_select) == 1)
    else $error("result does not select exactly one column");

  // decimal point never lit, and decimal digits always map to a lit pattern
  a_dp_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_o.segments[7] == 1'b1) && (out_o.segments != 8'hFF))
    else $error("bad segment pattern on result");

  // a stalled scan at the end of the split pipeline holds its payload
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sp_vld && !adv) |=> sp_vld && $stable(sp_item))
    else $error("split pipeline moved while stalled");

  // the pipeline only stalls on a scan
  a_stall_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |-> sp_vld && (sp_item.op == OP_SCAN))
    else $error("pipeline stalled without a pending scan");

endmodule
`default_nettype wire

### verif/tb_multiplexed_decimal_seven_segment_scan.sv
`timescale 1ns / 1ps
// Testbench for the seven-segment scan driver: directed and random beats checked by a local model.
module tb_multiplexed_decimal_seven_segment_scan;
  import mdss_pkg::*;

  localparam int unsigned StallCycles = 300;
  localparam int unsigned QuietLimit  = 2000;

  // lit segments per digit, bit0 = a ... bit6 = g
  localparam logic [7:0] DigitLit [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h67
  };

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic push    = 1'b0;
  logic pop     = 1'b0;
  in_t  in_beat = '0;
  logic full;
  logic empty;
  out_t out_beat;

  multiplexed_decimal_seven_segment_scan i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .in_i   (in_beat),
    .empty  (empty),
    .pop    (pop),
    .out_o  (out_beat)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  in_t  pending_beats [$];
  out_t expected_scans [$];

  // display state as the block should hold it
  logic [3:0]      shown_digits [NumDigits] = '{default: '0};
  logic [ColW-1:0] shown_column = '0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned stall_requests = 0;
  int unsigned stall_seen     = 0;
  int unsigned stall_left     = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned errors         = 0;

  task automatic apply_beat(input in_t beat);
    logic [16:0] rest;
    int unsigned col;
    out_t        scan;
    if (beat.kind == OP_LOAD) begin
      rest = {1'b0, beat.value};
      for (int i = 0; i < NumDigits; i++) begin
        shown_digits[i] = 4'(rest % 10);
        rest            = rest / 10;
      end
    end else begin
      // column moves first, then shows
      col = shown_column + 1;
      if (col >= DigitCount || col >= NumDigits) col = 0;
      shown_column       = col[ColW-1:0];
      scan.column_select = ~(5'b00001 << col);
      scan.segments      = (shown_digits[col] > 4'd9) ? 8'hFF : ~DigitLit[shown_digits[col]];
      expected_scans.push_back(scan);
    end
  endtask

  // driver: an offered beat stays put until the block takes it
  always @(posedge clk_i) begin
    if (push && !full) begin
      apply_beat(in_beat);
      void'(pending_beats.pop_front());
    end
    if (push && full) begin
      push <= 1'b1;
    end else if (rst_ni && pending_beats.size() != 0 &&
                 $urandom_range(0, 99) >= send_idle_pct) begin
      push    <= 1'b1;
      in_beat <= pending_beats[0];
    end else begin
      push <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_t due;
    if (pop && !empty) begin
      if (expected_scans.size() == 0) begin
        $error("result beat with no scan waiting: %h", out_beat);
        errors++;
      end else begin
        due = expected_scans.pop_front();
        if (out_beat.column_select !== due.column_select) begin
          $error("column_select: expected %h, got %h", due.column_select,
                 out_beat.column_select);
          errors++;
        end
        if (out_beat.segments !== due.segments) begin
          $error("segments: expected %h, got %h", due.segments, out_beat.segments);
          errors++;
        end
      end
    end
    if (stall_requests != stall_seen) begin
      stall_seen <= stall_requests;
      stall_left <= StallCycles;
      pop        <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      pop        <= 1'b0;
    end else begin
      pop <= rst_ni && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) ||
        (pending_beats.size() == 0 && expected_scans.size() == 0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic queue_item(input op_e op, input logic [15:0] value);
    in_t beat;
    beat.kind  = op;
    beat.value = value;
    pending_beats.push_back(beat);
  endtask

  task automatic queue_random(input int unsigned count);
    logic [15:0] value;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0:       value = 16'd0;
          1:       value = 16'hFFFF;
          2:       value = 16'd9999;
          default: value = 16'd10000;
        endcase
      end else begin
        value = 16'($urandom_range(0, 65535));
      end
      // mostly scans so each load gets shown across several columns
      if ($urandom_range(0, 99) < 25) queue_item(OP_LOAD, value);
      else queue_item(OP_SCAN, value);
    end
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || expected_scans.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 35;
    recv_idle_pct = 80;
    // ticks straight out of reset start at column 1
    queue_item(OP_SCAN, 16'h0000);
    queue_item(OP_SCAN, 16'hFFFF);
    queue_item(OP_LOAD, 16'hFFFF);
    repeat (4) queue_item(OP_SCAN, 16'h0000);
    // back-to-back loads, column must not move
    queue_item(OP_LOAD, 16'd0);
    queue_item(OP_LOAD, 16'd56789 - 16'd0);
    repeat (4) queue_item(OP_SCAN, 16'h5555);
    queue_item(OP_LOAD, 16'd1234);
    repeat (4) queue_item(OP_SCAN, 16'hAAAA);
    queue_item(OP_LOAD, 16'd10000);
    repeat (2) queue_item(OP_SCAN, 16'h0000);
    queue_item(OP_LOAD, 16'd9999);
    queue_item(OP_SCAN, 16'h0000);
    queue_random(550);
    drain();

    send_idle_pct = 80;
    recv_idle_pct = 35;
    queue_random(550);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(530);
    stall_requests++;
    drain();

    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
